### design/sbmt_pkg.sv
// Shared types and constants for the sparse byte memory table unit.
// No dependencies; the top level and the checker import this package.
package sbmt_pkg;

   localparam int ADDR_W = 32;
   localparam int BYTE_W = 8;
   localparam int DATA_W = 32;
   localparam int LANES  = 4;
   localparam int LANE_W = 2;

   // Command codes
   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // Access size codes (any other code is a word access)
   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;
   localparam logic [1:0] SIZE_WORD = 2'd2;

   typedef struct packed {
      logic              command;
      logic [1:0]        access_size;
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] write_data;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              table_full;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE,
      ST_RESP
   } state_type;

   // Index of the last byte lane touched by an access of the given size
   function automatic logic [LANE_W-1:0] last_lane(input logic [1:0] size);
      logic [LANE_W-1:0] res;
      unique case (size)
         SIZE_BYTE: res = LANE_W'(0);
         SIZE_HALF: res = LANE_W'(1);
         default:   res = LANE_W'(LANES - 1);
      endcase
      return res;
   endfunction

endpackage

### design/sbmt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sbmt_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/sparse_byte_memory_table_unit.sv
// Top level of the sparse byte memory table: sequencer, lane compare unit, result register.
// Depends on sbmt_pkg and sbmt_ram.
//
//   channel | direction | handshake              | payload
//   req_    | in        | req_valid / req_ready  | sbmt_pkg::req_type
//   rsp_    | out       | rsp_valid / rsp_ready  | sbmt_pkg::rsp_type
//
// A request is worked on in turns: the table RAM is scanned one entry per cycle through
// its single read port, all four byte lanes compared at once, then each byte of a write
// is written to the RAM in turn.
// Reset empties the table at once (used count to zero); no clearing pass.
// A stalled response sits in its output register while the next request is worked
// on; that request then waits for the register to drain before finishing.
module sparse_byte_memory_table_unit #(
   parameter int CAPACITY = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sbmt_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sbmt_pkg::rsp_type rsp_payload
);

   import sbmt_pkg::*;

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = ADDR_W + BYTE_W;

   // Control state
   state_type         state_ff, state_in;
   logic [CW-1:0]     used_ff, used_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Working state of the current request
   req_type           req_ff, req_in;
   logic [CW-1:0]     rd_idx_ff, rd_idx_in;
   logic [IW-1:0]     cmp_idx_ff, cmp_idx_in;
   logic [LANES-1:0]  hit_ff, hit_in;
   logic [IW-1:0]     idx_ff [LANES];
   logic [IW-1:0]     idx_in [LANES];
   logic [BYTE_W-1:0] byte_ff [LANES];
   logic [BYTE_W-1:0] byte_in [LANES];
   logic [LANE_W-1:0] lane_ff, lane_in;
   logic              full_ff, full_in;
   rsp_type           rsp_ff, rsp_in;

   // Datapath
   logic [ADDR_W-1:0] lane_addr [LANES];
   logic [LANE_W-1:0] last;
   logic [LANE_W-1:0] cur_sel;
   logic [BYTE_W-1:0] wr_byte;
   logic [DATA_W-1:0] read_value;
   logic              issue;

   // Table RAM ports
   logic              ram_wr_en;
   logic [IW-1:0]     ram_wr_addr;
   logic [EW-1:0]     ram_wr_data;
   logic [EW-1:0]     ram_rd_data;
   logic [ADDR_W-1:0] ent_addr;
   logic [BYTE_W-1:0] ent_byte;

   sbmt_ram #(
      .WIDTH (EW),
      .DEPTH (CAPACITY)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (issue),
      .rd_addr (rd_idx_ff[IW-1:0]),
      .rd_data (ram_rd_data)
   );

   assign ent_addr = ram_rd_data[EW-1:BYTE_W];
   assign ent_byte = ram_rd_data[BYTE_W-1:0];

   // Byte lane addresses, wrapping at 32 bits
   always_comb begin
      for (int b = 0; b < LANES; b++) begin
         lane_addr[b] = req_ff.address + ADDR_W'(b);
      end
   end

   assign last    = last_lane(req_ff.access_size);
   assign cur_sel = last - lane_ff;
   assign wr_byte = BYTE_W'(req_ff.write_data >> {cur_sel, 3'b000});
   assign issue   = (state_ff == ST_SCAN) && (rd_idx_ff < used_ff);

   // Assemble the big-endian read value from the lanes that hit
   always_comb begin
      read_value = '0;
      for (int b = 0; b < LANES; b++) begin
         if ((LANE_W'(b) <= last) && hit_ff[b]) begin
            read_value = read_value
                       | (DATA_W'(byte_ff[b]) << {last - LANE_W'(b), 3'b000});
         end
      end
   end

   // Sequencer: next state, scan, lane writes, response
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rd_idx_in    = rd_idx_ff;
      cmp_vld_in   = issue;
      cmp_idx_in   = rd_idx_ff[IW-1:0];
      hit_in       = hit_ff;
      idx_in       = idx_ff;
      byte_in      = byte_ff;
      used_in      = used_ff;
      lane_in      = lane_ff;
      full_in      = full_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = idx_ff[lane_ff];
      ram_wr_data  = {lane_addr[lane_ff], wr_byte};
      req_ready    = 1'b0;

      // Compare the entry just read against all four lane addresses
      if (cmp_vld_ff) begin
         for (int b = 0; b < LANES; b++) begin
            if (!hit_ff[b] && (ent_addr == lane_addr[b])) begin
               hit_in[b]  = 1'b1;
               idx_in[b]  = cmp_idx_ff;
               byte_in[b] = ent_byte;
            end
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in    = req_payload;
               rd_idx_in = '0;
               hit_in    = '0;
               lane_in   = '0;
               full_in   = 1'b0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Advance the read pointer; leave once the last compare is done
            if (issue) begin
               rd_idx_in = rd_idx_ff + CW'(1);
            end else if (!cmp_vld_ff) begin
               state_in = (req_ff.command == CMD_WRITE) ? ST_WRITE : ST_RESP;
            end
         end
         ST_WRITE: begin
            // Update in place, append, or drop when the table is full
            if (hit_ff[lane_ff]) begin
               ram_wr_en = 1'b1;
            end else if (used_ff < CW'(CAPACITY)) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = used_ff[IW-1:0];
               used_in     = used_ff + CW'(1);
            end else begin
               full_in = 1'b1;
            end
            if (lane_ff == last) begin
               state_in = ST_RESP;
            end else begin
               lane_in = lane_ff + LANE_W'(1);
            end
         end
         ST_RESP: begin
            // Load the output register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_in.read_data  = (req_ff.command == CMD_WRITE) ? '0 : read_value;
               rsp_in.table_full = full_ff;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers
   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      rd_idx_ff  <= rd_idx_in;
      cmp_idx_ff <= cmp_idx_in;
      hit_ff     <= hit_in;
      idx_ff     <= idx_in;
      byte_ff    <= byte_in;
      lane_ff    <= lane_in;
      full_ff    <= full_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### design/sbmt_checker.sv
// Port-level checker for the sparse byte memory table unit, and its bind.
// Depends on sbmt_pkg; binds to sparse_byte_memory_table_unit.
module sbmt_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input sbmt_pkg::rsp_type rsp_payload
);

   import sbmt_pkg::*;

   logic [1:0] pend_ff, pend_in;
   logic       req_acc, rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   // Track requests accepted but not yet answered
   always_comb begin
      pend_in = pend_ff + 2'(req_acc) - 2'(rsp_acc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response dropped or changed while stalled");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("response without an outstanding request");

   a_two_deep: assert property (@(posedge clock) disable iff (reset)
      pend_ff == 2'd2 |-> !req_ready)
      else $error("request taken with two already outstanding");

   a_full_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.table_full |-> rsp_payload.read_data == '0)
      else $error("table full flagged on a response carrying read data");

endmodule

bind sparse_byte_memory_table_unit sbmt_checker u_sbmt_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

### verif/tb.sv
// Self-checking testbench for sparse_byte_memory_table_unit: directed and random requests
// with a byte-table mirror that predicts every response. Depends on sbmt_pkg and the design.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sbmt_pkg::*;

   localparam int CAPACITY     = 256;
   localparam int RANDOM_ITEMS = 1900;
   localparam int LIMIT        = 3_000_000;
   // Size code outside the named ones; the block treats it as a word
   localparam logic [1:0] SIZE_ODD = 2'd3;

   // Mirror of the byte table: predicts each response and checks what comes back
   class sparse_memory_mirror;
      logic [ADDR_W-1:0] slot_addr [CAPACITY];
      logic [BYTE_W-1:0] slot_data [CAPACITY];
      int fill;
      rsp_type owed[$];
      int errors;
      int reads;
      int writes;
      int dropped;

      function int lookup(input logic [ADDR_W-1:0] a);
         for (int i = 0; i < fill; i++) begin
            if (slot_addr[i] == a) return i;
         end
         return -1;
      endfunction

      // Apply one accepted request to the mirror and queue its response
      function void note_request(input req_type r);
         int n;
         int k;
         int sh;
         logic [ADDR_W-1:0] a;
         logic [BYTE_W-1:0] v;
         rsp_type want;
         case (r.access_size)
            SIZE_BYTE: n = 1;
            SIZE_HALF: n = 2;
            default:   n = 4;
         endcase
         want = '0;
         for (int b = 0; b < n; b++) begin
            a  = r.address + ADDR_W'(b);
            sh = 8 * (n - 1 - b);
            k  = lookup(a);
            if (r.command == CMD_WRITE) begin
               v = r.write_data[sh +: 8];
               if (k >= 0) begin
                  slot_data[k] = v;
               end else if (fill < CAPACITY) begin
                  slot_addr[fill] = a;
                  slot_data[fill] = v;
                  fill++;
               end else begin
                  want.table_full = 1'b1;
               end
            end else if (k >= 0) begin
               want.read_data[sh +: 8] = slot_data[k];
            end
         end
         if (r.command == CMD_WRITE) writes++;
         else reads++;
         if (want.table_full) dropped++;
         owed.push_back(want);
      endfunction

      // Compare one accepted response with the oldest prediction
      function void check_response(input rsp_type got);
         rsp_type want;
         if (owed.size() == 0) begin
            $display("%0t: response %h with no request outstanding", $time, got);
            errors++;
            return;
         end
         want = owed.pop_front();
         if (got.read_data !== want.read_data) begin
            $display("%0t: read_data expected %h, got %h", $time,
                     want.read_data, got.read_data);
            errors++;
         end
         if (got.table_full !== want.table_full) begin
            $display("%0t: table_full expected %b, got %b", $time,
                     want.table_full, got.table_full);
            errors++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;

   sparse_memory_mirror mirror = new;
   bit quiet_tx;
   int cycles = 0;

   sparse_byte_memory_table_unit #(.CAPACITY(CAPACITY)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   // Offer one request after a random gap and hold it until accepted
   task automatic send_request(input logic cmd, input logic [1:0] size,
                               input logic [ADDR_W-1:0] addr,
                               input logic [DATA_W-1:0] data);
      req_type r;
      int gap;
      r.command     = cmd;
      r.access_size = size;
      r.address     = addr;
      r.write_data  = data;
      gap = quiet_tx ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      mirror.note_request(r);
   endtask

   // Hold off new requests until every response is back
   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (mirror.owed.size() != 0);
   endtask

   // Response side: random stall before each response
   initial begin : rsp_side
      int stall;
      bit quiet_rx;
      rsp_ready = 1'b0;
      quiet_rx  = 1'b0;
      repeat (3) @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) quiet_rx = ~quiet_rx;
         stall = quiet_rx ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         mirror.check_response(rsp_payload);
      end
   end

   initial begin : req_side
      logic [ADDR_W-1:0] region_base [3];
      logic [ADDR_W-1:0] addr;
      quiet_tx    = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      region_base[0] = 32'hFFFF_FFE0;
      region_base[1] = $urandom;
      region_base[2] = 32'h7FFF_FFF0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty reads, every size, wrap at the top address, overlaps
      send_request(CMD_READ,  SIZE_WORD, 32'h0000_0000, 32'h0);
      send_request(CMD_WRITE, SIZE_BYTE, 32'h0000_0000, 32'hFFFF_FF5A);
      send_request(CMD_READ,  SIZE_BYTE, 32'h0000_0000, 32'h0);
      send_request(CMD_WRITE, SIZE_HALF, 32'hFFFF_FFFF, 32'hABCD_1234);
      send_request(CMD_READ,  SIZE_WORD, 32'hFFFF_FFFE, 32'h0);
      send_request(CMD_WRITE, SIZE_WORD, 32'h0000_0010, 32'hDEAD_BEEF);
      send_request(CMD_READ,  SIZE_HALF, 32'h0000_0011, 32'h0);
      send_request(CMD_WRITE, SIZE_ODD,  32'hFFFF_FFFD, 32'hCAFE_F00D);
      send_request(CMD_READ,  SIZE_ODD,  32'hFFFF_FFFD, 32'h0);
      send_request(CMD_READ,  SIZE_BYTE, 32'hFFFF_FFFF, 32'h0);
      send_request(CMD_WRITE, SIZE_WORD, 32'h7FFF_FFFE, 32'hFFFF_FFFF);
      send_request(CMD_WRITE, SIZE_WORD, 32'h7FFF_FFFF, 32'h0000_0000);
      send_request(CMD_READ,  SIZE_WORD, 32'h7FFF_FFFE, 32'h0);
      send_request(CMD_WRITE, SIZE_BYTE, 32'h8000_0000, 32'hFFFF_FFFF);
      send_request(CMD_READ,  SIZE_HALF, 32'h7FFF_FFFF, 32'h0);
      send_request(CMD_WRITE, SIZE_HALF, 32'h0000_0012, 32'h0000_0000);
      send_request(CMD_READ,  SIZE_WORD, 32'h0000_0010, 32'h0);
      send_request(CMD_READ,  SIZE_WORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

      // Random: first half stays in three small regions so reads hit and the table
      // grows slowly; second half mixes in scattered addresses that fill it
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if ($urandom_range(0, 39) == 0) quiet_tx = ~quiet_tx;
         if (i == RANDOM_ITEMS / 2 || $urandom_range(0, 99) == 0) drain_responses();
         if (i >= RANDOM_ITEMS / 2 && $urandom_range(0, 99) < 25)
            addr = $urandom;
         else
            addr = region_base[$urandom_range(0, 2)] + ADDR_W'($urandom_range(0, 47));
         send_request(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), addr,
                      $urandom);
      end
      req_valid <= 1'b0;

      // Let every response come home, then watch for strays
      while (mirror.owed.size() != 0) @(posedge clock);
      repeat (CAPACITY + 16) @(posedge clock);

      $display("summary: %0d reads and %0d writes checked, table holds %0d of %0d entries,",
               mirror.reads, mirror.writes, mirror.fill, CAPACITY);
      $display("summary: %0d writes dropped bytes on a full table", mirror.dropped);
      if (mirror.errors == 0 && mirror.owed.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
